// ----- rtl/core/aeqp_pkg.sv -----
// Shared types, codes and constants of the Accept-Encoding q-value parser.
package aeqp_pkg;

	// Parser states; codes above the error state are never entered.
	typedef enum logic [3:0] {
		ST_START       = 4'd0,
		ST_NAME        = 4'd1,
		ST_NAME_SP     = 4'd2,
		ST_QVAL        = 4'd3,
		ST_Q           = 4'd4,
		ST_EQ          = 4'd5,
		ST_POINT       = 4'd6,
		ST_TENTHS      = 4'd7,
		ST_HUNDREDTHS  = 4'd8,
		ST_THOUSANDTHS = 4'd9,
		ST_AFTER_Q     = 4'd10,
		ST_ERROR       = 4'd11
	} state_t;

	// Kinds of result word.
	typedef enum logic [1:0] {
		K_NAME  = 2'd0,
		K_ENTRY = 2'd1,
		K_ERROR = 2'd2,
		K_DONE  = 2'd3
	} kind_t;

	localparam logic [10:0] Q_ONE      = 11'd1000;
	localparam logic [10:0] Q_ZERO     = 11'd0;
	localparam logic [10:0] Q_TENTH    = 11'd100;
	localparam logic [10:0] Q_HUNDREDTH = 11'd10;

	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Result queue depth and the fill level up to which a new word may enter.
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);
	localparam logic [OQ_CW-1:0] OQ_ROOM_LEVEL = OQ_CW'(OQ_DEPTH - 4);
	localparam logic [OQ_CW-1:0] OQ_FULL_LEVEL = OQ_CW'(OQ_DEPTH);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_byte;
		logic [10:0] quality;
		logic        last_of_run;
	} res_t;

	// What one parsed word leaves for the result queue: zero, one or two results.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} step_res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] b, logic [10:0] q);
		res_t r;
		r.kind        = k;
		r.name_byte   = b;
		r.quality     = q;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

// ----- rtl/core/aeqp_in_if.sv -----
// Input channel of the parser: one header character or end-of-header word.
interface aeqp_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_in;

	modport source (output valid, output mode, output char_in, input ready);
	modport sink (input valid, input mode, input char_in, output ready);
endinterface

// ----- rtl/core/aeqp_out_if.sv -----
// Output channel of the parser: one result word.
interface aeqp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  name_byte;
	logic [10:0] quality;
	logic        last_of_run;

	modport source (output valid, output kind, output name_byte, output quality,
		output last_of_run, input ready);
	modport sink (input valid, input kind, input name_byte, input quality,
		input last_of_run, output ready);
endinterface

// ----- rtl/core/aeqp_core.sv -----
// Parser core: input register, parser state, q-value accumulator and result decode.
module aeqp_core
	import aeqp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic       mode,
	input  logic [7:0] char_in,
	output step_res_t  res
);

	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  char_s1;
	state_t      state_q;
	state_t      state_nxt;
	logic [10:0] acc_q;
	logic [10:0] acc_nxt;

	logic        ws;
	logic        dig;
	logic [10:0] dig_v;
	logic [10:0] acc_tenths;
	logic [10:0] acc_hundredths;
	logic [10:0] acc_thousandths;
	logic [1:0]  cnt;
	res_t        r0;
	res_t        r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			mode_s1 <= mode;
			char_s1 <= char_in;
		end
	end

	assign ws  = (char_s1 == CH_SPACE) || ((char_s1 >= CH_TAB) && (char_s1 <= CH_CR));
	assign dig = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign dig_v = dig ? 11'(char_s1 - CH_ZERO) : 11'd0;

	// The accumulator wraps at eleven bits.
	assign acc_tenths      = acc_q + dig_v * Q_TENTH;
	assign acc_hundredths  = acc_q + dig_v * Q_HUNDREDTH;
	assign acc_thousandths = acc_q + dig_v;

	// Next state and accumulator.
	always_comb begin
		state_nxt = state_q;
		acc_nxt   = acc_q;
		if (mode_s1) begin
			state_nxt = ST_START;
			acc_nxt   = Q_ZERO;
		end else begin
			case (state_q)
				ST_START: begin
					if (!ws) state_nxt = ST_NAME;
				end
				ST_NAME: begin
					if (char_s1 == CH_SEMI) state_nxt = ST_Q;
					else if (char_s1 == CH_COMMA) state_nxt = ST_START;
					else if (ws) state_nxt = ST_NAME_SP;
				end
				ST_NAME_SP: begin
					if (char_s1 == CH_SEMI) state_nxt = ST_Q;
					else if (char_s1 == CH_COMMA) state_nxt = ST_START;
					else if (!ws) state_nxt = ST_ERROR;
				end
				ST_Q: begin
					if (char_s1 == CH_Q) state_nxt = ST_EQ;
					else if (!ws) state_nxt = ST_ERROR;
				end
				ST_EQ: begin
					if (char_s1 == CH_EQ) state_nxt = ST_QVAL;
					else if (!ws) state_nxt = ST_ERROR;
				end
				ST_QVAL: begin
					if (char_s1 == CH_ZERO) begin
						acc_nxt   = Q_ZERO;
						state_nxt = ST_POINT;
					end else if (char_s1 == CH_ONE) begin
						acc_nxt   = Q_ONE;
						state_nxt = ST_POINT;
					end else if (!ws) begin
						state_nxt = ST_ERROR;
					end
				end
				ST_POINT: begin
					if (char_s1 == CH_DOT) state_nxt = ST_TENTHS;
					else if (char_s1 == CH_COMMA) state_nxt = ST_START;
					else if (ws) state_nxt = ST_AFTER_Q;
					else state_nxt = ST_ERROR;
				end
				ST_AFTER_Q: begin
					if (char_s1 == CH_COMMA) state_nxt = ST_START;
					else if (!ws) state_nxt = ST_ERROR;
				end
				ST_TENTHS: begin
					if (dig) begin
						acc_nxt   = acc_tenths;
						state_nxt = ST_HUNDREDTHS;
					end else if (ws) begin
						state_nxt = ST_AFTER_Q;
					end
				end
				ST_HUNDREDTHS: begin
					if (dig) begin
						acc_nxt   = acc_hundredths;
						state_nxt = ST_THOUSANDTHS;
					end else if (char_s1 == CH_COMMA) begin
						state_nxt = ST_START;
					end else if (ws) begin
						state_nxt = ST_AFTER_Q;
					end
				end
				ST_THOUSANDTHS: begin
					if (dig) begin
						acc_nxt   = acc_thousandths;
						state_nxt = ST_AFTER_Q;
					end else if (char_s1 == CH_COMMA) begin
						state_nxt = ST_START;
					end else if (ws) begin
						state_nxt = ST_AFTER_Q;
					end else begin
						state_nxt = ST_ERROR;
					end
				end
				default: begin
					state_nxt = state_q;
				end
			endcase
		end
	end

	// Results of the word in the input register.
	always_comb begin
		cnt = 2'd0;
		r0  = mk_res(K_NAME, 8'd0, Q_ZERO);
		r1  = mk_res(K_DONE, 8'd0, Q_ZERO);
		if (mode_s1) begin
			cnt = 2'd2;
			case (state_q)
				ST_NAME, ST_NAME_SP: r0 = mk_res(K_ENTRY, 8'd0, Q_ONE);
				ST_QVAL, ST_POINT, ST_TENTHS, ST_HUNDREDTHS, ST_THOUSANDTHS:
					r0 = mk_res(K_ENTRY, 8'd0, acc_q);
				ST_Q, ST_EQ: r0 = mk_res(K_ERROR, 8'd0, Q_ZERO);
				default: begin
					cnt = 2'd1;
					r0  = mk_res(K_DONE, 8'd0, Q_ZERO);
				end
			endcase
		end else begin
			case (state_q)
				ST_START: begin
					if (!ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_NAME, char_s1, Q_ZERO);
					end
				end
				ST_NAME: begin
					if (char_s1 == CH_COMMA) begin
						cnt = 2'd1;
						r0  = mk_res(K_ENTRY, 8'd0, Q_ONE);
					end else if (char_s1 != CH_SEMI && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_NAME, char_s1, Q_ZERO);
					end
				end
				ST_NAME_SP: begin
					if (char_s1 == CH_COMMA) begin
						cnt = 2'd1;
						r0  = mk_res(K_ENTRY, 8'd0, Q_ONE);
					end else if (char_s1 != CH_SEMI && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_Q: begin
					if (char_s1 != CH_Q && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_EQ: begin
					if (char_s1 != CH_EQ && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_QVAL: begin
					if (char_s1 != CH_ZERO && char_s1 != CH_ONE && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_POINT: begin
					if (char_s1 == CH_COMMA || ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ENTRY, 8'd0, acc_q);
					end else if (char_s1 != CH_DOT) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_AFTER_Q: begin
					if (char_s1 != CH_COMMA && !ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ERROR, 8'd0, Q_ZERO);
					end
				end
				ST_TENTHS: begin
					if (!dig && ws) begin
						cnt = 2'd1;
						r0  = mk_res(K_ENTRY, 8'd0, acc_q);
					end
				end
				ST_HUNDREDTHS: begin
					if (!dig && (char_s1 == CH_COMMA || ws)) begin
						cnt = 2'd1;
						r0  = mk_res(K_ENTRY, 8'd0, acc_q);
					end
				end
				ST_THOUSANDTHS: begin
					cnt = 2'd1;
					if (dig) r0 = mk_res(K_ENTRY, 8'd0, acc_thousandths);
					else if (char_s1 == CH_COMMA || ws) r0 = mk_res(K_ENTRY, 8'd0, acc_q);
					else r0 = mk_res(K_ERROR, 8'd0, Q_ZERO);
				end
				default: begin
					cnt = 2'd0;
				end
			endcase
		end
		r0.last_of_run = (cnt == 2'd1);
		r1.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			acc_q   <= Q_ZERO;
		end else if (valid_s1) begin
			state_q <= state_nxt;
			acc_q   <= acc_nxt;
		end
	end

	assign res.cnt = valid_s1 ? cnt : 2'd0;
	assign res.r0  = r0;
	assign res.r1  = r1;

	// Two results come only from an end-of-header word.
	a_two_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res.cnt == 2'd2) |-> mode_s1)
		else $error("two results from a header character");

	// An end-of-header word leaves the parser in its reset state.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mode_s1) |=> (state_q == ST_START && acc_q == Q_ZERO))
		else $error("parser not reset after end of header");

	// An error is reported at most once: never from the error state.
	a_error_once: assert property (@(posedge clk) disable iff (!arst_n)
		(res.cnt != 2'd0 && res.r0.kind == K_ERROR) |-> (state_q != ST_ERROR))
		else $error("syntax error reported twice");

	// The error state is left only by the end of the header.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !mode_s1 && state_q == ST_ERROR) |=> (state_q == ST_ERROR))
		else $error("error state left on a header character");

endmodule

// ----- rtl/core/aeqp_outq.sv -----
// Result queue: takes up to two result words per cycle, gives one per cycle on pop.
module aeqp_outq
	import aeqp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  step_res_t push,
	input  logic      pop,
	output logic      valid,
	output res_t      head,
	output logic      room
);

	res_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] count_q;
	logic             do_pop;

	assign valid  = (count_q != '0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = valid && pop;
	// Room for a word in the input register and one more behind it.
	assign room   = (count_q <= OQ_ROOM_LEVEL);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) mem_q[wr_ptr_q] <= push.r0;
		if (push.cnt == 2'd2) mem_q[wr_ptr_q + OQ_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_AW'(push.cnt);
			rd_ptr_q <= rd_ptr_q + OQ_AW'(do_pop);
			count_q  <= count_q + OQ_CW'(push.cnt) - OQ_CW'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + OQ_CW'(push.cnt)) <= OQ_FULL_LEVEL)
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OQ_FULL_LEVEL)
		else $error("result queue count out of range");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd0 && !do_pop) |=> $stable(count_q))
		else $error("result queue count moved without push or pop");

endmodule

// ----- rtl/core/accept_encoding_qvalue_parser.sv -----
// Top level of the Accept-Encoding q-value parser.
// Path: an accepted word is held in the input register and decoded there against
// the parser state; its results are written into the result queue, whose head
// drives the result word.
// Throughput: one input word per cycle while the queue has room, one result word out
// per cycle, so only end-of-header words (up to two results) slow a fully loaded stream.
// Reset: arst_n clears the parser state, the q-value accumulator and the result queue.
module accept_encoding_qvalue_parser
	import aeqp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	aeqp_in_if.sink        hdr,
	aeqp_out_if.source     evt
);

	// The parser core registers each accepted word, then decodes it against the
	// current parser state in one short step: at most a compare of the byte
	// against a few characters and an eleven-bit add of a constant-scaled digit.
	// Every decoded word pushes zero, one or two results into the queue, which
	// keeps the result side apart from the input side so that a stalled consumer
	// does not stop the parser until the queue runs short of room.
	step_res_t step_res;
	res_t      head;
	logic      room;
	logic      take;

	// A new word is taken only when the queue can absorb the worst case of the
	// word now in the input register plus the new one.
	assign hdr.ready = room;
	assign take      = hdr.valid && room;

	aeqp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.mode    (hdr.mode),
		.char_in (hdr.char_in),
		.res     (step_res)
	);

	aeqp_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step_res),
		.pop    (evt.ready),
		.valid  (evt.valid),
		.head   (head),
		.room   (room)
	);

	// The head of the queue drives the result word directly.
	assign evt.kind        = head.kind;
	assign evt.name_byte   = head.name_byte;
	assign evt.quality     = head.quality;
	assign evt.last_of_run = head.last_of_run;

	// Nothing is taken while the queue lacks room.
	a_take_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> room)
		else $error("input word taken without queue room");

	// A taken end-of-header word always yields at least one result in the cycle after it
	// is taken; a header character may yield none.
	a_end_yields: assert property (@(posedge clk) disable iff (!arst_n)
		(take && hdr.mode) |=> (step_res.cnt != 2'd0))
		else $error("end of header produced no result");

	// Each done word closes its run.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(evt.valid && head.kind == K_DONE) |-> head.last_of_run)
		else $error("done word not marked last");

endmodule

// ----- bench/aeqp_checker.sv -----
// Result checker for the Accept-Encoding q-value parser: predicts and scores result words.
`timescale 1ns / 100ps
module aeqp_checker
	import aeqp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	aeqp_in_if   hdr,
	aeqp_out_if  evt,
	output int   fail_count,
	output int   pending,
	output int   live_words,
	output int   entries_seen,
	output int   errors_seen,
	output int   headers_seen
);

	state_t      pstate;
	logic [10:0] qacc;
	res_t        events_due[$];
	res_t        run_buf[2];
	int          run_len;
	int          n_fail  = 0;
	int          n_live  = 0;
	int          n_entry = 0;
	int          n_err   = 0;
	int          n_done  = 0;

	function automatic logic is_space(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	task automatic add_event(kind_t k, logic [7:0] b, logic [10:0] q);
		run_buf[run_len] = '{kind: k, name_byte: b, quality: q, last_of_run: 1'b0};
		run_len++;
	endtask

	task automatic syntax_fail();
		add_event(K_ERROR, 8'h00, Q_ZERO);
		pstate = ST_ERROR;
	endtask

	task automatic parse_char(logic [7:0] c);
		logic        ws;
		logic        dig;
		logic [10:0] d;
		ws  = is_space(c);
		dig = c >= CH_ZERO && c <= CH_NINE;
		d   = dig ? 11'(c - CH_ZERO) : Q_ZERO;
		case (pstate)
			ST_START: begin
				if (!ws) begin
					add_event(K_NAME, c, Q_ZERO);
					pstate = ST_NAME;
				end
			end
			ST_NAME: begin
				if (c == CH_SEMI) pstate = ST_Q;
				else if (c == CH_COMMA) begin
					add_event(K_ENTRY, 8'h00, Q_ONE);
					pstate = ST_START;
				end else if (ws) pstate = ST_NAME_SP;
				else add_event(K_NAME, c, Q_ZERO);
			end
			ST_NAME_SP: begin
				if (c == CH_SEMI) pstate = ST_Q;
				else if (c == CH_COMMA) begin
					add_event(K_ENTRY, 8'h00, Q_ONE);
					pstate = ST_START;
				end else if (!ws) syntax_fail();
			end
			ST_Q: begin
				if (c == CH_Q) pstate = ST_EQ;
				else if (!ws) syntax_fail();
			end
			ST_EQ: begin
				if (c == CH_EQ) pstate = ST_QVAL;
				else if (!ws) syntax_fail();
			end
			ST_QVAL: begin
				if (c == CH_ZERO) begin
					qacc   = Q_ZERO;
					pstate = ST_POINT;
				end else if (c == CH_ONE) begin
					qacc   = Q_ONE;
					pstate = ST_POINT;
				end else if (!ws) syntax_fail();
			end
			ST_POINT: begin
				if (c == CH_DOT) pstate = ST_TENTHS;
				else if (c == CH_COMMA) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_START;
				end else if (ws) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_AFTER_Q;
				end else syntax_fail();
			end
			ST_AFTER_Q: begin
				if (c == CH_COMMA) pstate = ST_START;
				else if (!ws) syntax_fail();
			end
			// Anything but a digit or whitespace is dropped here.
			ST_TENTHS: begin
				if (dig) begin
					qacc   = qacc + d * Q_TENTH;
					pstate = ST_HUNDREDTHS;
				end else if (ws) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_AFTER_Q;
				end
			end
			ST_HUNDREDTHS: begin
				if (dig) begin
					qacc   = qacc + d * Q_HUNDREDTH;
					pstate = ST_THOUSANDTHS;
				end else if (c == CH_COMMA) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_START;
				end else if (ws) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_AFTER_Q;
				end
			end
			ST_THOUSANDTHS: begin
				if (dig) begin
					qacc = qacc + d;
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_AFTER_Q;
				end else if (c == CH_COMMA) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_START;
				end else if (ws) begin
					add_event(K_ENTRY, 8'h00, qacc);
					pstate = ST_AFTER_Q;
				end else syntax_fail();
			end
			default: ;
		endcase
	endtask

	task automatic finish_header();
		case (pstate)
			ST_NAME, ST_NAME_SP: add_event(K_ENTRY, 8'h00, Q_ONE);
			ST_QVAL, ST_POINT, ST_TENTHS, ST_HUNDREDTHS, ST_THOUSANDTHS:
				add_event(K_ENTRY, 8'h00, qacc);
			ST_Q, ST_EQ: add_event(K_ERROR, 8'h00, Q_ZERO);
			default: ;
		endcase
		add_event(K_DONE, 8'h00, Q_ZERO);
		pstate = ST_START;
		qacc   = Q_ZERO;
	endtask

	task automatic report_bad(string what, res_t want, res_t got);
		n_fail++;
		if (n_fail <= 10)
			$display("%0t: %s: expected kind %0d byte %02h q %0d last %0b, %s",
				$realtime, what, want.kind, want.name_byte, want.quality,
				want.last_of_run,
				$sformatf("got kind %0d byte %02h q %0d last %0b",
					got.kind, got.name_byte, got.quality, got.last_of_run));
	endtask

	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			pstate = ST_START;
			qacc   = Q_ZERO;
			events_due.delete();
		end else begin
			if (evt.valid && evt.ready) begin
				got.kind        = kind_t'(evt.kind);
				got.name_byte   = evt.name_byte;
				got.quality     = evt.quality;
				got.last_of_run = evt.last_of_run;
				if (events_due.size() == 0) begin
					want = '0;
					report_bad("unexpected word", want, got);
				end else begin
					want = events_due.pop_front();
					if (got.kind !== want.kind || got.name_byte !== want.name_byte ||
							got.quality !== want.quality ||
							got.last_of_run !== want.last_of_run)
						report_bad("mismatch", want, got);
					case (want.kind)
						K_ENTRY: n_entry++;
						K_ERROR: n_err++;
						K_DONE:  n_done++;
						default: ;
					endcase
				end
			end
			if (hdr.valid && hdr.ready) begin
				run_len = 0;
				if (hdr.mode) begin
					n_live++;
					finish_header();
				end else begin
					if (pstate != ST_ERROR) n_live++;
					parse_char(hdr.char_in);
				end
				for (int i = 0; i < run_len; i++) begin
					if (i == run_len - 1) run_buf[i].last_of_run = 1'b1;
					events_due.push_back(run_buf[i]);
				end
			end
		end
		fail_count   <= n_fail;
		pending      <= events_due.size();
		live_words   <= n_live;
		entries_seen <= n_entry;
		errors_seen  <= n_err;
		headers_seen <= n_done;
	end

endmodule

// ----- bench/tb_accept_encoding_qvalue_parser.sv -----
// Testbench top for the Accept-Encoding q-value parser: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_accept_encoding_qvalue_parser;
	import aeqp_pkg::*;

	// Stimulus stops at the end of the header during which this many words
	// have been sent.
	localparam int ITEM_TARGET = 850;
	// Cycles without any accepted word before the run is declared hung. The
	// longest legal quiet stretch is a sender gap plus a choked receiver, far
	// below this.
	localparam int IDLE_LIMIT  = 2000;

	typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_style_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	aeqp_in_if  hdr();
	aeqp_out_if evt();

	int fail_count;
	int pending;
	int live_words;
	int entries_seen;
	int errors_seen;
	int headers_seen;

	int         idle_cycles = 0;
	int         burst_left  = 0;
	int         sent_words  = 0;
	int         sent_headers = 0;
	logic [7:0] line[$];

	accept_encoding_qvalue_parser u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hdr    (hdr),
		.evt    (evt)
	);

	// The checker sees both channels and does all prediction and comparison.
	aeqp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.hdr          (hdr),
		.evt          (evt),
		.fail_count   (fail_count),
		.pending      (pending),
		.live_words   (live_words),
		.entries_seen (entries_seen),
		.errors_seen  (errors_seen),
		.headers_seen (headers_seen)
	);

	always #10 clk = ~clk;

	// Watchdog: any handshake on either side counts as progress.
	always @(posedge clk) begin
		if ((hdr.valid && hdr.ready) || (evt.valid && evt.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result receiver. It switches at random among a few stall styles so that
	// back-pressure lands on every phase of the parser's work, including long
	// stretches where it never stalls at all.
	initial begin
		rx_style_t style;
		int        style_left;
		int        tick;
		style      = RX_OPEN;
		style_left = 0;
		tick       = 0;
		evt.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style      = rx_style_t'($urandom_range(0, 3));
				style_left = $urandom_range(20, 120);
			end
			style_left--;
			tick++;
			case (style)
				RX_OPEN:     evt.ready <= 1'b1;
				RX_COIN:     evt.ready <= $urandom_range(0, 1) == 1;
				RX_PERIODIC: evt.ready <= (tick % 7) < 5;
				RX_CHOKED:   evt.ready <= $urandom_range(0, 9) == 0;
				default:     evt.ready <= 1'b1;
			endcase
		end
	end

	// Offers one word and holds it until the parser takes it. Words go out in
	// bursts; at the end of a burst the valid line drops for a random gap,
	// which may also be zero so that back-to-back bursts occur.
	task automatic send_word(input logic m, input logic [7:0] c);
		int gap;
		hdr.valid   <= 1'b1;
		hdr.mode    <= m;
		hdr.char_in <= c;
		do @(posedge clk); while (hdr.ready !== 1'b1);
		sent_words++;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				hdr.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end else begin
			burst_left--;
		end
	endtask

	// Sends the characters collected in line, then the end-of-header word.
	task automatic send_line();
		foreach (line[i]) send_word(1'b0, line[i]);
		send_word(1'b1, 8'($urandom_range(0, 255)));
		sent_headers++;
	endtask

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
	endfunction

	// A byte that continues a name: letters half of the time, otherwise any
	// byte that is neither whitespace nor a separator, high bytes included.
	function automatic logic [7:0] name_char();
		logic [7:0] c;
		if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
		do c = 8'($urandom_range(0, 255));
		while (c == CH_SEMI || c == CH_COMMA || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
		return c;
	endfunction

	task automatic maybe_space();
		if ($urandom_range(0, 3) == 0) line.push_back(space_char());
	endtask

	// Builds a well-formed header of one to four entries with random names,
	// optional q parameters, random whitespace and anything from zero to three
	// decimal places.
	task automatic build_header();
		int n_entries;
		int n_name;
		int n_dig;
		line.delete();
		n_entries = $urandom_range(1, 4);
		for (int e = 0; e < n_entries; e++) begin
			if (e > 0) line.push_back(CH_COMMA);
			maybe_space();
			n_name = $urandom_range(1, 6);
			repeat (n_name) line.push_back(name_char());
			maybe_space();
			if ($urandom_range(0, 2) != 0) begin
				line.push_back(CH_SEMI);
				maybe_space();
				line.push_back(CH_Q);
				maybe_space();
				line.push_back(CH_EQ);
				maybe_space();
				line.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
				if ($urandom_range(0, 4) != 0) begin
					line.push_back(CH_DOT);
					n_dig = $urandom_range(0, 3);
					repeat (n_dig) line.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
				end
				maybe_space();
			end
		end
	endtask

	initial begin
		int pick;
		int pos;
		int n_noise;
		hdr.valid   <= 1'b0;
		hdr.mode    <= 1'b0;
		hdr.char_in <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed headers.
		// An empty header gives only the done word.
		line.delete();
		send_line();
		// Header ending right after ';': a syntax error, then done. Name byte 0xFF.
		line = '{8'hFF, CH_SEMI};
		send_line();
		// Header ending after ';q': the same error path from the '=' wait. Name byte 0x00.
		line = '{8'h00, CH_SEMI, CH_Q};
		send_line();
		// Largest quality: q=1.999, ending after the quality has been reported.
		line = '{8'h61, CH_SEMI, CH_Q, CH_EQ, CH_ONE, CH_DOT, CH_NINE, CH_NINE, CH_NINE};
		send_line();
		// Second word of a name after a space is an error; the rest is dropped and
		// the end word gives only done.
		line = '{8'h61, CH_SPACE, 8'h62, CH_COMMA};
		send_line();

		// Random headers: mostly well formed, some with a byte overwritten or cut
		// short, and now and then pure noise.
		while (sent_words < ITEM_TARGET) begin
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				line.delete();
				n_noise = $urandom_range(1, 12);
				repeat (n_noise) line.push_back(8'($urandom_range(0, 255)));
			end else begin
				build_header();
				if (pick <= 2) begin
					pos = $urandom_range(0, line.size() - 1);
					line[pos] = 8'($urandom_range(0, 255));
				end else if (pick == 3) begin
					pos = $urandom_range(0, line.size() - 1);
					while (line.size() > pos) void'(line.pop_back());
				end
			end
			send_line();
		end

		hdr.valid <= 1'b0;
		// Let the last prediction reach the checker, drain the results, then
		// watch a little longer for any stray word.
		repeat (3) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d words in %0d headers (%0d not dropped after errors).",
			sent_words, sent_headers, live_words);
		$display("Checked %0d entries, %0d syntax errors and %0d done words.",
			entries_seen, errors_seen, headers_seen);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
